@@ sv/xte_pkg.sv @@
// ----------------------------------------------------------------------------
// XML text escaper package
// Shared item types, command format between front and back, and the
// character tables of the entity strings.
// ----------------------------------------------------------------------------
package xte_pkg;

	localparam int HOLD_DEPTH = 4;
	localparam int NUM_NAMES  = 5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_MATCH   = 2'd1,
		MODE_NUMERIC = 2'd2
	} escape_mode_t;

	// String that opens a command's output.
	typedef enum logic [1:0] {
		LEAD_NONE    = 2'd0,
		LEAD_AMP_ENT = 2'd1,
		LEAD_AMP     = 2'd2,
		LEAD_HASH    = 2'd3
	} lead_t;

	// String that closes a command's output.
	typedef enum logic [2:0] {
		TAIL_NONE    = 3'd0,
		TAIL_BYTE    = 3'd1,
		TAIL_QUOT    = 3'd2,
		TAIL_APOS    = 3'd3,
		TAIL_LT      = 3'd4,
		TAIL_GT      = 3'd5,
		TAIL_AMP_ENT = 3'd6
	} tail_t;

	// One queued command: lead string, held letters, tail string.
	typedef struct packed {
		lead_t                           lead;
		tail_t                           tail;
		logic [HOLD_DEPTH-1:0][7:0]      held;
		logic [7:0]                      ch;
		logic                            done;
		logic [2:0]                      held_end;  // end of lead segment
		logic [3:0]                      tail_start;
		logic [3:0]                      total;
	} cmd_t;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;

	// Strings are left aligned in six byte slots.
	localparam logic [47:0] STR_AMP_ENT = {"&amp;", 8'h00};
	localparam logic [47:0] STR_QUOT    = "&quot;";
	localparam logic [47:0] STR_APOS    = "&apos;";
	localparam logic [47:0] STR_LT      = {"&lt;", 16'h0000};
	localparam logic [47:0] STR_GT      = {"&gt;", 16'h0000};
	localparam logic [47:0] STR_HASH    = {"&#", 32'h0000_0000};
	localparam logic [47:0] STR_AMP     = {"&", 40'h00_0000_0000};

	function automatic logic [7:0] pick(input logic [47:0] s, input logic [2:0] idx);
		return s[47 - 8*idx -: 8];
	endfunction

	function automatic logic [2:0] lead_len(input lead_t l);
		case (l)
			LEAD_AMP_ENT: return 3'd5;
			LEAD_AMP:     return 3'd1;
			LEAD_HASH:    return 3'd2;
			default:      return 3'd0;
		endcase
	endfunction

	function automatic logic [2:0] tail_len(input tail_t t);
		case (t)
			TAIL_BYTE:    return 3'd1;
			TAIL_QUOT:    return 3'd6;
			TAIL_APOS:    return 3'd6;
			TAIL_LT:      return 3'd4;
			TAIL_GT:      return 3'd4;
			TAIL_AMP_ENT: return 3'd5;
			default:      return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] lead_char(input lead_t l, input logic [2:0] idx);
		case (l)
			LEAD_AMP_ENT: return pick(STR_AMP_ENT, idx);
			LEAD_AMP:     return pick(STR_AMP, idx);
			LEAD_HASH:    return pick(STR_HASH, idx);
			default:      return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] tail_char(input tail_t t, input logic [7:0] ch,
			input logic [2:0] idx);
		case (t)
			TAIL_BYTE:    return ch;
			TAIL_QUOT:    return pick(STR_QUOT, idx);
			TAIL_APOS:    return pick(STR_APOS, idx);
			TAIL_LT:      return pick(STR_LT, idx);
			TAIL_GT:      return pick(STR_GT, idx);
			TAIL_AMP_ENT: return pick(STR_AMP_ENT, idx);
			default:      return 8'h00;
		endcase
	endfunction

	// How a byte of plain text is written out.
	function automatic tail_t normal_tail(input logic [7:0] c);
		case (c)
			CH_QUOT: return TAIL_QUOT;
			CH_APOS: return TAIL_APOS;
			CH_LT:   return TAIL_LT;
			CH_GT:   return TAIL_GT;
			CH_AMP:  return TAIL_NONE;
			default: return TAIL_BYTE;
		endcase
	endfunction

	// Entity strings, the leading ampersand and terminating semicolon included.
	function automatic logic [47:0] entity_str(input logic [2:0] k);
		case (k)
			3'd0:    return STR_AMP_ENT;
			3'd1:    return STR_QUOT;
			3'd2:    return STR_APOS;
			3'd3:    return STR_LT;
			default: return STR_GT;
		endcase
	endfunction

	function automatic logic [2:0] name_len(input logic [2:0] k);
		case (k)
			3'd0:    return 3'd4;
			3'd1:    return 3'd5;
			3'd2:    return 3'd5;
			default: return 3'd3;
		endcase
	endfunction

	function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] i);
		return pick(entity_str(k), 3'(i + 3'd1));
	endfunction

endpackage

@@ sv/xte_in_if.sv @@
// ----------------------------------------------------------------------------
// XML text escaper input channel
// Valid/ready channel that carries one text byte per transfer.
// ----------------------------------------------------------------------------
interface xte_in_if;
	logic              valid;
	logic              ready;
	xte_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/xte_out_if.sv @@
// ----------------------------------------------------------------------------
// XML text escaper output channel
// Valid/ready channel that carries one escaped byte per transfer.
// ----------------------------------------------------------------------------
interface xte_out_if;
	logic               valid;
	logic               ready;
	xte_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/xte_front.sv @@
// ----------------------------------------------------------------------------
// XML text escaper front end
// Accepts input bytes, tracks the escape mode and the held entity letters,
// and turns each byte into at most one output command for the queue.
// ----------------------------------------------------------------------------
module xte_front (
	input  logic          clk,
	input  logic          arst_n,
	xte_in_if.sink        in_ch,
	output logic          push_valid,
	input  logic          push_ready,
	output xte_pkg::cmd_t push_cmd
);

	xte_pkg::escape_mode_t                         mode_q, mode_d;
	logic [2:0]                                    count_q, count_d;
	logic [xte_pkg::HOLD_DEPTH-1:0][7:0]          held_q, held_d;
	logic                                          accept;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;

	always_comb begin
		logic [7:0]  c;
		logic        last;
		logic [2:0]  len;
		logic [7:0]  cand;
		logic        hit;
		logic        any_prefix;
		logic        any_full;
		logic        numeric;
		logic [2:0]  held_n;
		xte_pkg::lead_t lead;
		xte_pkg::tail_t tail;
		logic [3:0]  tstart;

		c    = in_ch.data.in_byte;
		last = in_ch.data.end_of_text;
		len  = 3'(count_q + 3'd1);

		// Compare held letters plus the new byte against every entity name.
		any_prefix = 1'b0;
		any_full   = 1'b0;
		for (int k = 0; k < xte_pkg::NUM_NAMES; k++) begin
			hit = (len <= xte_pkg::name_len(3'(k)));
			for (int i = 0; i < xte_pkg::HOLD_DEPTH + 1; i++) begin
				if (3'(i) < count_q && i < xte_pkg::HOLD_DEPTH) begin
					cand = held_q[i[1:0]];
				end else begin
					cand = c;
				end
				if (3'(i) < len && cand != xte_pkg::name_char(3'(k), 3'(i))) begin
					hit = 1'b0;
				end
			end
			if (hit && len == xte_pkg::name_len(3'(k))) begin
				any_full = 1'b1;
			end else if (hit) begin
				any_prefix = 1'b1;
			end
		end
		numeric = (count_q == 3'd0) && (c == xte_pkg::CH_HASH);

		mode_d  = mode_q;
		count_d = count_q;
		held_d  = held_q;
		lead    = xte_pkg::LEAD_NONE;
		tail    = xte_pkg::TAIL_NONE;
		held_n  = 3'd0;

		case (mode_q)
			xte_pkg::MODE_MATCH: begin
				if (numeric) begin
					lead   = xte_pkg::LEAD_HASH;
					mode_d = xte_pkg::MODE_NUMERIC;
					count_d = 3'd0;
				end else if (any_full) begin
					lead    = xte_pkg::LEAD_AMP;
					held_n  = count_q;
					tail    = xte_pkg::TAIL_BYTE;
					mode_d  = xte_pkg::MODE_NORMAL;
					count_d = 3'd0;
				end else if (any_prefix) begin
					held_d[count_q[1:0]] = c;
					count_d = len;
					if (last) begin
						// Text ends inside a name: give up and emit the letters.
						lead   = xte_pkg::LEAD_AMP_ENT;
						held_n = len;
					end
				end else begin
					lead    = xte_pkg::LEAD_AMP_ENT;
					held_n  = count_q;
					tail    = xte_pkg::normal_tail(c);
					count_d = 3'd0;
					mode_d  = (c == xte_pkg::CH_AMP) ? xte_pkg::MODE_MATCH
						: xte_pkg::MODE_NORMAL;
					if (last && c == xte_pkg::CH_AMP) begin
						tail = xte_pkg::TAIL_AMP_ENT;
					end
				end
			end
			xte_pkg::MODE_NUMERIC: begin
				tail = xte_pkg::TAIL_BYTE;
				if (c == xte_pkg::CH_SEMI) begin
					mode_d = xte_pkg::MODE_NORMAL;
				end
			end
			default: begin
				tail = xte_pkg::normal_tail(c);
				if (c == xte_pkg::CH_AMP) begin
					mode_d  = xte_pkg::MODE_MATCH;
					count_d = 3'd0;
					if (last) begin
						tail = xte_pkg::TAIL_AMP_ENT;
					end
				end
			end
		endcase

		if (last) begin
			mode_d  = xte_pkg::MODE_NORMAL;
			count_d = 3'd0;
		end

		tstart                = 4'(xte_pkg::lead_len(lead)) + 4'(held_n);
		push_cmd.lead         = lead;
		push_cmd.tail         = tail;
		push_cmd.held         = held_d;
		push_cmd.ch           = c;
		push_cmd.done         = last;
		push_cmd.held_end     = xte_pkg::lead_len(lead);
		push_cmd.tail_start   = tstart;
		push_cmd.total        = tstart + 4'(xte_pkg::tail_len(tail));
	end

	// Items that only extend a held name produce nothing and are not queued.
	assign push_valid = in_ch.valid && (push_cmd.total != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= xte_pkg::MODE_NORMAL;
			count_q <= 3'd0;
		end else if (accept) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

@@ sv/xte_queue.sv @@
// ----------------------------------------------------------------------------
// XML text escaper command queue
// Small FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module xte_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  xte_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output xte_pkg::cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	xte_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ sv/xte_back.sv @@
// ----------------------------------------------------------------------------
// XML text escaper back end
// Walks the head command to the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module xte_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  xte_pkg::cmd_t cmd,
	xte_out_if.source     out_ch
);

	logic [3:0]         pos_q;
	logic               out_valid_q;
	xte_pkg::out_item_t out_item_q;
	logic               advance;
	logic               last;
	logic [7:0]         byte_sel;
	logic [3:0]         off_held;
	logic [3:0]         off_tail;

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_item_q;

	assign advance  = cmd_valid && (!out_valid_q || out_ch.ready);
	assign last     = (pos_q == 4'(cmd.total - 4'd1));
	assign cmd_pop  = advance && last;
	assign off_held = pos_q - 4'(cmd.held_end);
	assign off_tail = pos_q - cmd.tail_start;

	always_comb begin
		if (pos_q < 4'(cmd.held_end)) begin
			byte_sel = xte_pkg::lead_char(cmd.lead, pos_q[2:0]);
		end else if (pos_q < cmd.tail_start) begin
			byte_sel = cmd.held[off_held[1:0]];
		end else begin
			byte_sel = xte_pkg::tail_char(cmd.tail, cmd.ch, off_tail[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q       <= last ? 4'd0 : 4'(pos_q + 4'd1);
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q.out_byte  <= byte_sel;
			out_item_q.run_last  <= last;
			out_item_q.text_done <= last && cmd.done;
		end
	end

endmodule

@@ sv/xml_text_escaper_unit.sv @@
// ----------------------------------------------------------------------------
// XML text escaper unit
// Streaming XML text escaper with entity recognition and numeric references.
// ----------------------------------------------------------------------------
// The unit takes text one byte per transfer and writes escaped XML text one
// byte per transfer. Double quote, apostrophe, less-than and greater-than
// become their named entities; an ampersand that already starts one of the
// five named entities is passed through, an ampersand followed by '#' opens
// a numeric reference that is copied raw through the next semicolon, and any
// other ampersand becomes "&amp;". A byte with end_of_text set closes the
// text and returns all state to its reset values. Rate: the input side takes
// one byte per cycle as long as the command queue has room; the output side
// delivers one byte per cycle, while the output is not stalled, through a
// single output register, and an input byte expands to 0 to 15 output bytes.
// Sustained throughput is therefore one input byte per cycle for plain text,
// and is set by the output register's one byte per cycle when text expands;
// the queue of QUEUE_DEPTH commands lets bursts of expansion overlap with
// further input.
// ----------------------------------------------------------------------------
module xml_text_escaper_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	xte_in_if.sink    in_ch,
	xte_out_if.source out_ch
);

	// Front end to queue.
	logic          push_valid;
	logic          push_ready;
	xte_pkg::cmd_t push_cmd;

	// Queue to back end.
	logic          pop_valid;
	logic          pop_ready;
	xte_pkg::cmd_t pop_cmd;

	// The front end classifies each byte against the current escape mode and
	// the held letters, and emits at most one command naming the bytes to write.
	xte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Commands wait here so the front can keep taking bytes while the back
	// is still expanding an earlier one.
	xte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// The back end writes a command's bytes one transfer at a time and marks
	// the last byte of each command and of the whole text.
	xte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_pop   (pop_ready),
		.cmd       (pop_cmd),
		.out_ch    (out_ch)
	);

endmodule

@@ verif/xml_text_escaper_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML text escaper unit testbench
// Sends a directed set of texts and then random texts built from markup
// characters, named entities, numeric references and broken entities. Every
// escaped byte is checked against a software escaper kept in step with the
// input transfers. Both channels idle in random bursts, and the output side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module xml_text_escaper_unit_test;

	// The limit leaves several times the length of a slow but correct run of
	// about 400 bytes with up to 15 results each under long stalls.
	localparam int CYCLE_LIMIT  = 600_000;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_TAIL    = 60;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	// Two queued commands of up to 15 bytes each, plus the output register.
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS  = 10;
	localparam int MAX_STEP     = 16;

	localparam logic [7:0]      CH_ZERO      = 8'h30;
	localparam logic [3:0][7:0] MARKUP_CHARS = {xte_pkg::CH_QUOT, xte_pkg::CH_APOS,
		xte_pkg::CH_LT, xte_pkg::CH_GT};

	typedef enum logic [1:0] {
		MATCH_NONE,
		MATCH_PREFIX,
		MATCH_FULL,
		MATCH_NUMERIC
	} match_t;

	typedef enum int {
		TOK_PLAIN,
		TOK_MARKUP,
		TOK_ENTITY,
		TOK_NUMERIC,
		TOK_BROKEN,
		TOK_LONE_AMP,
		TOK_NOISE
	} token_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	xte_in_if  in_ch ();
	xte_out_if out_ch ();

	// Local copies give every input of the unit a known value from time zero.
	logic              in_valid  = 1'b0;
	xte_pkg::in_item_t in_data   = '0;
	logic              out_ready = 1'b0;

	assign in_ch.valid  = in_valid;
	assign in_ch.data   = in_data;
	assign out_ch.ready = out_ready;

	xml_text_escaper_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial forever #6 clk = ~clk;

	// Stimulus and bookkeeping.
	xte_pkg::in_item_t  text_bytes [$];
	logic [7:0]         text_buf [$];
	xte_pkg::out_item_t expected_bytes [$];
	xte_pkg::out_item_t step_bytes [$];
	int                 total_items;
	int                 directed_items;
	int                 text_count;
	int                 sent_count;
	int                 received_count;
	int                 mismatch_count;
	int                 longest_step;
	int                 cycle_count;
	int                 send_gap;
	int                 recv_gap;
	int                 hold_left;
	logic               hold_done;

	// Escaper state as the unit should hold it.
	xte_pkg::escape_mode_t text_mode = xte_pkg::MODE_NORMAL;
	logic [7:0]            held [xte_pkg::HOLD_DEPTH];
	int                    held_n;

	xte_pkg::out_item_t got_byte;
	xte_pkg::out_item_t want_byte;

	function automatic string entity_name(int k);
		case (k)
			0:       return "amp;";
			1:       return "quot;";
			2:       return "apos;";
			3:       return "lt;";
			default: return "gt;";
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Expected-output predictor
	// ------------------------------------------------------------------------

	function automatic void emit(logic [7:0] b);
		xte_pkg::out_item_t r;
		r.out_byte  = b;
		r.run_last  = 1'b0;
		r.text_done = 1'b0;
		if (step_bytes.size() < MAX_STEP)
			step_bytes.push_back(r);
	endfunction

	function automatic void emit_string(string s);
		for (int i = 0; i < s.len(); i++)
			emit(s[i]);
	endfunction

	// A broken entity: the ampersand is escaped and the held letters follow.
	function automatic void flush_ampersand();
		emit_string("&amp;");
		for (int i = 0; i < held_n; i++)
			emit(held[i]);
		held_n    = 0;
		text_mode = xte_pkg::MODE_NORMAL;
	endfunction

	function automatic void plain_byte(logic [7:0] c);
		case (c)
			xte_pkg::CH_QUOT: emit_string("&quot;");
			xte_pkg::CH_APOS: emit_string("&apos;");
			xte_pkg::CH_LT:   emit_string("&lt;");
			xte_pkg::CH_GT:   emit_string("&gt;");
			xte_pkg::CH_AMP: begin
				text_mode = xte_pkg::MODE_MATCH;
				held_n    = 0;
			end
			default: emit(c);
		endcase
	endfunction

	// Classifies the held letters plus the new byte against the entity names.
	function automatic match_t classify(logic [7:0] c);
		logic [7:0] cand [xte_pkg::HOLD_DEPTH+1];
		int         len;
		bit         prefix;
		bit         same;
		string      name;
		for (int i = 0; i < held_n; i++)
			cand[i] = held[i];
		cand[held_n] = c;
		len    = held_n + 1;
		prefix = 1'b0;
		if (len == 1 && c == xte_pkg::CH_HASH)
			return MATCH_NUMERIC;
		for (int k = 0; k < xte_pkg::NUM_NAMES; k++) begin
			name = entity_name(k);
			if (len <= name.len()) begin
				same = 1'b1;
				for (int i = 0; i < len; i++)
					if (cand[i] != name[i])
						same = 1'b0;
				if (same) begin
					if (len == name.len())
						return MATCH_FULL;
					prefix = 1'b1;
				end
			end
		end
		return prefix ? MATCH_PREFIX : MATCH_NONE;
	endfunction

	// Works out the bytes that one accepted input byte must produce and
	// queues them behind the ones still outstanding.
	function automatic void escape_byte(xte_pkg::in_item_t item);
		logic [7:0]         c;
		match_t             m;
		xte_pkg::out_item_t last;
		c = item.in_byte;
		step_bytes.delete();
		case (text_mode)
			xte_pkg::MODE_MATCH: begin
				m = classify(c);
				if (m == MATCH_PREFIX && held_n < xte_pkg::HOLD_DEPTH) begin
					held[held_n] = c;
					held_n++;
				end else if (m == MATCH_FULL) begin
					// A complete entity passes through as written.
					emit(xte_pkg::CH_AMP);
					for (int i = 0; i < held_n; i++)
						emit(held[i]);
					emit(c);
					held_n    = 0;
					text_mode = xte_pkg::MODE_NORMAL;
				end else if (m == MATCH_NUMERIC) begin
					emit_string("&#");
					held_n    = 0;
					text_mode = xte_pkg::MODE_NUMERIC;
				end else begin
					// The breaking byte is then treated as plain text and may
					// itself open a new match.
					flush_ampersand();
					plain_byte(c);
				end
			end
			xte_pkg::MODE_NUMERIC: begin
				emit(c);
				if (c == xte_pkg::CH_SEMI)
					text_mode = xte_pkg::MODE_NORMAL;
			end
			default: plain_byte(c);
		endcase
		if (item.end_of_text) begin
			// An unfinished entity name is escaped; an open numeric reference
			// is simply left unterminated.
			if (text_mode == xte_pkg::MODE_MATCH)
				flush_ampersand();
			text_mode = xte_pkg::MODE_NORMAL;
			held_n    = 0;
		end
		if (step_bytes.size() > 0) begin
			last           = step_bytes[step_bytes.size()-1];
			last.run_last  = 1'b1;
			last.text_done = item.end_of_text;
			step_bytes[step_bytes.size()-1] = last;
		end
		if (step_bytes.size() > longest_step)
			longest_step = step_bytes.size();
		foreach (step_bytes[i])
			expected_bytes.push_back(step_bytes[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Text construction
	// ------------------------------------------------------------------------

	function automatic void add_char(logic [7:0] b);
		text_buf.push_back(b);
	endfunction

	function automatic void add_string(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	// Moves the text under construction to the send queue and flags its
	// final byte.
	function automatic void close_text();
		xte_pkg::in_item_t it;
		foreach (text_buf[i]) begin
			it.in_byte     = text_buf[i];
			it.end_of_text = (i == text_buf.size() - 1);
			text_bytes.push_back(it);
		end
		if (text_buf.size() > 0)
			text_count++;
		text_buf.delete();
	endfunction

	function automatic void add_random_text();
		token_t kind;
		string  name;
		int     cut;
		repeat ($urandom_range(1, 8)) begin
			kind = token_t'($urandom_range(0, int'(TOK_NOISE)));
			case (kind)
				TOK_PLAIN: add_char(8'($urandom_range(0, 255)));
				TOK_MARKUP: add_char(MARKUP_CHARS[$urandom_range(0, 3)]);
				TOK_ENTITY: begin
					add_char(xte_pkg::CH_AMP);
					add_string(entity_name($urandom_range(0, xte_pkg::NUM_NAMES - 1)));
				end
				TOK_NUMERIC: begin
					add_char(xte_pkg::CH_AMP);
					add_char(xte_pkg::CH_HASH);
					repeat ($urandom_range(0, 5)) begin
						if ($urandom_range(0, 3) == 0)
							add_char(8'($urandom_range(0, 255)));
						else
							add_char(CH_ZERO + 8'($urandom_range(0, 9)));
					end
					// Now and then the reference runs on unterminated.
					if ($urandom_range(0, 5) != 0)
						add_char(xte_pkg::CH_SEMI);
				end
				TOK_BROKEN: begin
					name = entity_name($urandom_range(0, xte_pkg::NUM_NAMES - 1));
					cut  = $urandom_range(1, name.len() - 1);
					add_char(xte_pkg::CH_AMP);
					for (int i = 0; i < cut; i++)
						add_char(name[i]);
					add_char(8'($urandom_range(0, 255)));
				end
				TOK_LONE_AMP: add_char(xte_pkg::CH_AMP);
				default: begin
					repeat ($urandom_range(1, 4))
						add_char(8'($urandom_range(0, 255)));
				end
			endcase
		end
		close_text();
	endfunction

	// ------------------------------------------------------------------------
	// Input side: driver and transfer monitor
	// ------------------------------------------------------------------------

	// A new byte is offered once the previous one has transferred. Gaps come
	// in bursts and stop for the last stretch of the run and during the long
	// output hold-off, so that the unit backs up against the stalled output.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ch.ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (text_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else if (text_bytes.size() > CALM_TAIL && hold_left == 0 &&
					$urandom_range(0, 15) == 0) begin
				send_gap <= $urandom_range(1, 19) - 1;
				in_valid <= 1'b0;
			end else begin
				in_data  <= text_bytes.pop_front();
				in_valid <= 1'b1;
			end
		end
	end

	// Every byte that transfers into the unit is run through the predictor.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ch.ready) begin
			escape_byte(in_ch.data);
			sent_count <= sent_count + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Output side: long hold-off, ready pattern and checker
	// ------------------------------------------------------------------------

	// One long hold-off of the output once enough input has gone in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && sent_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap  <= recv_gap - 1;
			out_ready <= 1'b0;
		end else if (sent_count + CALM_TAIL < total_items && $urandom_range(0, 11) == 0) begin
			recv_gap  <= $urandom_range(1, 19) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void report_mismatch(string what, xte_pkg::out_item_t want,
			xte_pkg::out_item_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("Mismatch at output byte %0d (%s): expected %h last %b done %b,",
				received_count, what, want.out_byte, want.run_last, want.text_done,
				" got %h last %b done %b",
				got.out_byte, got.run_last, got.text_done);
	endfunction

	// Each escaped byte is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ready) begin
			got_byte = out_ch.data;
			if (expected_bytes.size() == 0) begin
				report_mismatch("no byte expected", '0, got_byte);
			end else begin
				want_byte = expected_bytes.pop_front();
				if (got_byte.out_byte !== want_byte.out_byte)
					report_mismatch("out_byte", want_byte, got_byte);
				else if (got_byte.run_last !== want_byte.run_last)
					report_mismatch("run_last", want_byte, got_byte);
				else if (got_byte.text_done !== want_byte.text_done)
					report_mismatch("text_done", want_byte, got_byte);
			end
			received_count++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d bytes outstanding",
				cycle_count, expected_bytes.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		// Directed texts: each markup character, the byte extremes, a named
		// entity passing through, a numeric reference, the longest expansion
		// (a four-letter prefix broken by an apostrophe), a doubled ampersand
		// whose second half opens a new match that the end of text cuts off,
		// and a numeric reference cut off by the end of text.
		add_string("\"'<>");
		close_text();
		add_char(8'h00);
		add_char(8'hFF);
		close_text();
		add_string("&lt;");
		close_text();
		add_string("&#9;");
		close_text();
		add_string("&quot'");
		close_text();
		add_string("&&g");
		close_text();
		add_string("&#1");
		close_text();
		directed_items = text_bytes.size();

		while (text_bytes.size() < directed_items + RANDOM_ITEMS)
			add_random_text();
		total_items = text_bytes.size();

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (sent_count < total_items)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		// Any extra byte the unit might still send shows up in this window.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_bytes.size() != 0) begin
			$display("%0d expected bytes never arrived", expected_bytes.size());
			mismatch_count += expected_bytes.size();
		end

		$display("Sent %0d bytes in %0d texts (%0d directed), checked %0d escaped bytes",
			total_items, text_count, directed_items, received_count);
		$display("Longest expansion %0d bytes from one input; output held off %0d cycles once",
			longest_step, HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatch_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
